// ===== rtl/kms_pkg.sv =====
// Shared types and constants for the demux key matrix scanner.
`default_nettype none
package kms_pkg;

  localparam int ROW_SENSE_W = 6;
  localparam int KEY_ROW_W   = 3;
  localparam int KEY_COL_W   = 3;
  localparam int SEL_CODE_W  = 3;
  localparam int CFG_COLS_W  = 4;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 2;

  localparam logic [APB_ADDR_W-1:0] ADDR_ACTIVE_COLUMNS = 2'd0;
  localparam logic [CFG_COLS_W-1:0] ACTIVE_COLUMNS_RST  = 4'd8;

  localparam logic REC_EVENT  = 1'b0;
  localparam logic REC_STATUS = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // input transaction taken this cycle
    logic step;        // walk one matrix cell
    logic load_mid;    // emit mid-scan status
    logic load_final;  // emit end-of-scan status
  } kms_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;    // current column is the last one of the pass
    logic cell_diff;   // walked cell differs from stored matrix
    logic cell_last;   // walked cell is the last of the pass
    logic out_free;    // output register can take a record
  } kms_status_t;

endpackage
`default_nettype wire

// ===== rtl/kms_in_if.sv =====
// Input channel: row sense bits for the selected column.
`default_nettype none
interface kms_in_if;
  import kms_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ROW_SENSE_W-1:0] row_sense;

  modport source (output valid, output row_sense, input ready);
  modport sink   (input valid, input row_sense, output ready);
endinterface
`default_nettype wire

// ===== rtl/kms_out_if.sv =====
// Result channel: key change events and status records.
`default_nettype none
interface kms_out_if;
  import kms_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  record_kind;
  logic [KEY_ROW_W-1:0]  key_row;
  logic [KEY_COL_W-1:0]  key_column;
  logic                  key_pressed;
  logic [SEL_CODE_W-1:0] select_code;
  logic                  scan_done;
  logic                  rescan_needed;
  logic                  last_record;

  modport source (output valid, output record_kind, output key_row, output key_column,
                  output key_pressed, output select_code, output scan_done,
                  output rescan_needed, output last_record, input ready);
  modport sink   (input valid, input record_kind, input key_row, input key_column,
                  input key_pressed, input select_code, input scan_done,
                  input rescan_needed, input last_record, output ready);
endinterface
`default_nettype wire

// ===== rtl/kms_ctrl.sv =====
// Scan sequencer: input acceptance, matrix walk and record emission control.
`default_nettype none
module kms_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  kms_pkg::kms_status_t status,
  output kms_pkg::kms_cmd_t    cmd
);
  import kms_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MID,
    ST_WALK,
    ST_FINAL
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    cmd            = '0;
    cmd.accept     = in_valid && in_ready_r;
    cmd.step       = (state_r == ST_WALK) && (!status.cell_diff || status.out_free);
    cmd.load_mid   = (state_r == ST_MID) && status.out_free;
    cmd.load_final = (state_r == ST_FINAL) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.accept) begin
            in_ready_r <= 1'b0;
            state_r    <= status.scan_end ? ST_WALK : ST_MID;
          end
        end
        ST_MID: begin
          if (cmd.load_mid) begin
            in_ready_r <= 1'b1;
            state_r    <= ST_IDLE;
          end
        end
        ST_WALK: begin
          if (cmd.step && status.cell_last) begin
            state_r <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (cmd.load_final) begin
            in_ready_r <= 1'b1;
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r    <= ST_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/kms_datapath.sv =====
// Scan datapath: column counter, scan buffer, key matrix, cell walker, output register.
`default_nettype none
module kms_datapath #(
  parameter int ROWS        = 6,
  parameter int MAX_COLUMNS = 8,
  parameter int SELECT_BITS = 3
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire  [kms_pkg::CFG_COLS_W-1:0]      active_columns,
  input  wire  [kms_pkg::ROW_SENSE_W-1:0]     row_sense,
  input  wire  kms_pkg::kms_cmd_t             cmd,
  output kms_pkg::kms_status_t                status,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic                                out_record_kind,
  output logic [kms_pkg::KEY_ROW_W-1:0]       out_key_row,
  output logic [kms_pkg::KEY_COL_W-1:0]       out_key_column,
  output logic                                out_key_pressed,
  output logic [kms_pkg::SEL_CODE_W-1:0]      out_select_code,
  output logic                                out_scan_done,
  output logic                                out_rescan_needed,
  output logic                                out_last_record
);
  import kms_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [SEL_CODE_W-1:0] SEL_MASK = SEL_CODE_W'((1 << SELECT_BITS) - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

  logic [CW-1:0]   cnt_r;
  logic [ROWS-1:0] buf_r [MAX_COLUMNS];
  logic [ROWS-1:0] km_r  [MAX_COLUMNS];
  logic [RW-1:0]   r_r;
  logic [CW-1:0]   c_r;
  logic            any_r;

  logic                  out_valid_r;
  logic                  kind_r;
  logic [KEY_ROW_W-1:0]  row_r;
  logic [KEY_COL_W-1:0]  col_r;
  logic                  pressed_r;
  logic [SEL_CODE_W-1:0] sel_r;
  logic                  done_r;
  logic                  rescan_r;
  logic                  last_r;

  logic [CW:0]                   ncols;
  logic [CW:0]                   cnt_inc;
  logic [CW:0]                   c_inc;
  logic [ROWS+ROW_SENSE_W-1:0]   sense_ext;
  logic [ROWS-1:0]               sense;
  logic                          now_bit;
  logic                          was_bit;
  logic                          out_free;
  logic [CW+SEL_CODE_W-1:0]      cnt_ext;
  logic [RW+KEY_ROW_W-1:0]       r_ext;
  logic [CW+KEY_COL_W-1:0]       c_ext;

  // zero means one column, counts past the array saturate
  always_comb begin
    priority if (active_columns == '0) begin
      ncols = (CW+1)'(1);
    end else if (active_columns > CFG_COLS_W'(MAX_COLUMNS)) begin
      ncols = (CW+1)'(MAX_COLUMNS);
    end else begin
      ncols = active_columns[CW:0];
    end
  end

  assign cnt_inc   = {1'b0, cnt_r} + (CW+1)'(1);
  assign c_inc     = {1'b0, c_r} + (CW+1)'(1);
  assign sense_ext = {{ROWS{1'b0}}, row_sense};
  assign sense     = sense_ext[ROWS-1:0];
  assign now_bit   = buf_r[c_r][r_r];
  assign was_bit   = km_r[c_r][r_r];
  assign out_free  = !out_valid_r || out_ready;
  assign cnt_ext   = {{SEL_CODE_W{1'b0}}, cnt_r};
  assign r_ext     = {{KEY_ROW_W{1'b0}}, r_r};
  assign c_ext     = {{KEY_COL_W{1'b0}}, c_r};

  always_comb begin
    status           = '0;
    status.scan_end  = (cnt_inc >= ncols);
    status.cell_diff = now_bit ^ was_bit;
    status.cell_last = (r_r == ROW_LAST) && (c_inc == ncols);
    status.out_free  = out_free;
  end

  // scan buffer has no reset; every entry read was written this pass
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      buf_r[cnt_r] <= sense;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      r_r   <= '0;
      c_r   <= '0;
      any_r <= 1'b0;
      for (int i = 0; i < MAX_COLUMNS; i++) begin
        km_r[i] <= '0;
      end
    end else begin
      if (cmd.accept) begin
        cnt_r <= status.scan_end ? '0 : cnt_inc[CW-1:0];
        r_r   <= '0;
        c_r   <= '0;
        any_r <= 1'b0;
      end else if (cmd.step) begin
        any_r <= any_r | now_bit;
        if (status.cell_diff) begin
          km_r[c_r][r_r] <= now_bit;
        end
        if (!status.cell_last) begin
          if (c_inc == ncols) begin
            c_r <= '0;
            r_r <= r_r + RW'(1);
          end else begin
            c_r <= c_inc[CW-1:0];
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.step && status.cell_diff) || cmd.load_mid || cmd.load_final) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && status.cell_diff) begin
      kind_r    <= REC_EVENT;
      row_r     <= r_ext[KEY_ROW_W-1:0];
      col_r     <= c_ext[KEY_COL_W-1:0];
      pressed_r <= now_bit;
      sel_r     <= '0;
      done_r    <= 1'b0;
      rescan_r  <= 1'b0;
      last_r    <= 1'b0;
    end else if (cmd.load_mid) begin
      // counter has already advanced to the next column
      kind_r    <= REC_STATUS;
      row_r     <= '0;
      col_r     <= '0;
      pressed_r <= 1'b0;
      sel_r     <= cnt_ext[SEL_CODE_W-1:0] & SEL_MASK;
      done_r    <= 1'b0;
      rescan_r  <= 1'b0;
      last_r    <= 1'b1;
    end else if (cmd.load_final) begin
      kind_r    <= REC_STATUS;
      row_r     <= '0;
      col_r     <= '0;
      pressed_r <= 1'b0;
      sel_r     <= '0;
      done_r    <= 1'b1;
      rescan_r  <= any_r;
      last_r    <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_record_kind   = kind_r;
  assign out_key_row       = row_r;
  assign out_key_column    = col_r;
  assign out_key_pressed   = pressed_r;
  assign out_select_code   = sel_r;
  assign out_scan_done     = done_r;
  assign out_rescan_needed = rescan_r;
  assign out_last_record   = last_r;

endmodule
`default_nettype wire

// ===== rtl/demux_key_matrix_scanner.sv =====
// Top level of the demux key matrix scanner: register port, sequencer and datapath.
//
// in_chan carries the row sense bits read while the column named by the last
// status record's select_code is driven. out_chan carries key change events
// followed by one status record that has last_record set. Both channels use
// valid/ready; a transaction moves when both are high.
// A mid-scan input gives one status record. The last column of a pass starts
// a walk of the key matrix, one cell per cycle while no changed cell waits on
// a stalled sink, rows outer and columns inner, through a single cell
// comparator. The input is not taken again until the walk and its end-of-scan
// status record are done.
// Results sit in one output register; a new input is taken while the last
// record of the previous item still waits there. A stalled sink holds the
// walk at the next differing cell.
// Reset clears the column counter and the stored key matrix (no keys down)
// and sets active_columns to 8. active_columns lies at byte address 0 of the
// APB port. Write it only while the block is idle; the block does not enforce it.
`default_nettype none
module demux_key_matrix_scanner #(
  parameter int ROWS        = 6,
  parameter int MAX_COLUMNS = 8,
  parameter int SELECT_BITS = 3
) (
  input  wire                               clk,
  input  wire                               rst_n,
  kms_in_if.sink                            in_chan,
  kms_out_if.source                         out_chan,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [kms_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire  [kms_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [kms_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import kms_pkg::*;

  logic [CFG_COLS_W-1:0] active_columns_r;
  kms_cmd_t              cmd;
  kms_status_t           status;
  logic                  in_ready;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_columns_r <= ACTIVE_COLUMNS_RST;
    end else if (psel && penable && pwrite && (paddr == ADDR_ACTIVE_COLUMNS)) begin
      active_columns_r <= pwdata[CFG_COLS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_ACTIVE_COLUMNS) begin
      prdata = {{(APB_DATA_W-CFG_COLS_W){1'b0}}, active_columns_r};
    end
  end

  assign in_chan.ready = in_ready;

  kms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  kms_datapath #(
    .ROWS        (ROWS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .SELECT_BITS (SELECT_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .active_columns    (active_columns_r),
    .row_sense         (in_chan.row_sense),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_record_kind   (out_chan.record_kind),
    .out_key_row       (out_chan.key_row),
    .out_key_column    (out_chan.key_column),
    .out_key_pressed   (out_chan.key_pressed),
    .out_select_code   (out_chan.select_code),
    .out_scan_done     (out_chan.scan_done),
    .out_rescan_needed (out_chan.rescan_needed),
    .out_last_record   (out_chan.last_record)
  );

endmodule
`default_nettype wire

// ===== tb/sv/kms_scan_checker.sv =====
// Checker for the key matrix scanner: watches both channels and the APB port, predicts records.
module kms_scan_checker (
  input  wire                            clk,
  input  wire                            rst_n,
  kms_in_if                              in_mon,
  kms_out_if                             out_mon,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire                            pready,
  input  wire [kms_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire [kms_pkg::APB_DATA_W-1:0]  pwdata,
  output int                             fail_count,
  output int                             open_count,
  output int                             records_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import kms_pkg::*;

  localparam int ROWS        = 6;
  localparam int MAX_COLUMNS = 8;

  typedef struct packed {
    logic                  kind;
    logic [KEY_ROW_W-1:0]  row;
    logic [KEY_COL_W-1:0]  column;
    logic                  pressed;
    logic [SEL_CODE_W-1:0] sel;
    logic                  scan_end;
    logic                  rescan;
    logic                  last_rec;
  } scan_rec_t;

  scan_rec_t              expected_records[$];
  logic [CFG_COLS_W-1:0]  cols_reg;
  logic [KEY_COL_W-1:0]   col_ptr;
  logic [ROW_SENSE_W-1:0] sense_buf[MAX_COLUMNS];
  logic [ROW_SENSE_W-1:0] key_state[MAX_COLUMNS];
  int                     errors  = 0;
  int                     checked = 0;

  function automatic scan_rec_t make_rec(logic kind, int row, int column, logic pressed,
                                         int sel, logic scan_end, logic rescan, logic last_rec);
    scan_rec_t rec;
    rec.kind     = kind;
    rec.row      = row[KEY_ROW_W-1:0];
    rec.column   = column[KEY_COL_W-1:0];
    rec.pressed  = pressed;
    rec.sel      = sel[SEL_CODE_W-1:0];
    rec.scan_end = scan_end;
    rec.rescan   = rescan;
    rec.last_rec = last_rec;
    return rec;
  endfunction

  // one row-sense transaction: store it, and at the last column diff the whole matrix
  task automatic predict_scan_step(input logic [ROW_SENSE_W-1:0] sense);
    int   ncols;
    int   cur;
    logic now_down;
    logic was_down;
    logic any_down;
    ncols = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_reg));
    cur = col_ptr;
    sense_buf[cur] = sense;
    if (cur + 1 < ncols) begin
      col_ptr = KEY_COL_W'(cur + 1);
      expected_records.push_back(make_rec(REC_STATUS, 0, 0, 1'b0, cur + 1, 1'b0, 1'b0, 1'b1));
      return;
    end
    any_down = 1'b0;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < ncols; c++) begin
        now_down = sense_buf[c][r];
        was_down = key_state[c][r];
        any_down |= now_down;
        if (now_down != was_down) begin
          key_state[c][r] = now_down;
          expected_records.push_back(make_rec(REC_EVENT, r, c, now_down, 0, 1'b0, 1'b0, 1'b0));
        end
      end
    end
    col_ptr = '0;
    expected_records.push_back(make_rec(REC_STATUS, 0, 0, 1'b0, 0, 1'b1, any_down, 1'b1));
  endtask

  function automatic int field_diff(string label, int want, int got);
    if (want != got) begin
      $display("%0t kms_scan_checker: %s mismatch, expected %0d, actual %0d",
               $time, label, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    scan_rec_t got;
    scan_rec_t want;
    if (!rst_n) begin
      cols_reg = ACTIVE_COLUMNS_RST;
      col_ptr  = '0;
      for (int c = 0; c < MAX_COLUMNS; c++) begin
        sense_buf[c] = '0;
        key_state[c] = '0;
      end
      expected_records.delete();
    end else begin
      // results first: a record leaving now was caused by an earlier transaction
      if (out_mon.valid && out_mon.ready) begin
        got.kind     = out_mon.record_kind;
        got.row      = out_mon.key_row;
        got.column   = out_mon.key_column;
        got.pressed  = out_mon.key_pressed;
        got.sel      = out_mon.select_code;
        got.scan_end = out_mon.scan_done;
        got.rescan   = out_mon.rescan_needed;
        got.last_rec = out_mon.last_record;
        checked++;
        if (expected_records.size() == 0) begin
          $display("%0t kms_scan_checker: unexpected record, expected none, actual %h",
                   $time, got);
          errors++;
        end else begin
          want = expected_records.pop_front();
          errors += field_diff("record_kind", want.kind, got.kind);
          errors += field_diff("key_row", want.row, got.row);
          errors += field_diff("key_column", want.column, got.column);
          errors += field_diff("key_pressed", want.pressed, got.pressed);
          errors += field_diff("select_code", want.sel, got.sel);
          errors += field_diff("scan_done", want.scan_end, got.scan_end);
          errors += field_diff("rescan_needed", want.rescan, got.rescan);
          errors += field_diff("last_record", want.last_rec, got.last_rec);
        end
      end
      if (in_mon.valid && in_mon.ready) predict_scan_step(in_mon.row_sense);
      if (psel && penable && pwrite && pready && paddr == ADDR_ACTIVE_COLUMNS)
        cols_reg = pwdata[CFG_COLS_W-1:0];
    end
    open_count      <= expected_records.size();
    fail_count      <= errors;
    records_checked <= checked;
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the key matrix scanner: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kms_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int HOLD_CYCLES  = 400;
  localparam int N_PHASES     = 9;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  kms_in_if  in_bus ();
  kms_out_if out_bus ();

  int   fail_count;
  int   open_count;
  int   records_checked;
  int   cycles         = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   items_sent     = 0;
  int   settings_count = 0;
  int   eff_cols       = 8;
  int   col_pos        = 0;
  bit   hold_go        = 1'b0;
  logic hold_off;
  logic [ROW_SENSE_W-1:0] held_rows[8];

  demux_key_matrix_scanner u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  kms_scan_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_bus),
    .out_mon         (out_bus),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .open_count      (open_count),
    .records_checked (records_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // receiver: random stalls, plus the long hold-off when requested
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    hold_off <= 1'b0;
    forever begin
      wait (hold_go);
      hold_go = 1'b0;
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  task automatic send_row(input logic [ROW_SENSE_W-1:0] sense);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.row_sense <= sense;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    items_sent++;
    col_pos = (col_pos + 1 < eff_cols) ? col_pos + 1 : 0;
  endtask

  // only while idle: every expected record out, then a short settle
  task automatic write_columns(input logic [CFG_COLS_W-1:0] value);
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ACTIVE_COLUMNS;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    eff_cols = (value == 0) ? 1 : ((value > 8) ? 8 : int'(value));
    settings_count++;
  endtask

  // mostly held keys per column, some single-key flips, some noise and releases
  function automatic logic [ROW_SENSE_W-1:0] next_row();
    int pick;
    logic [ROW_SENSE_W-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 55)      v = held_rows[col_pos];
    else if (pick < 80) v = held_rows[col_pos] ^ (6'h01 << $urandom_range(0, ROW_SENSE_W - 1));
    else if (pick < 90) v = ROW_SENSE_W'($urandom);
    else                v = '0;
    held_rows[col_pos] = v;
    return v;
  endfunction

  initial begin
    int idle_mode[4]  = '{0, 72, 0, 20};
    int stall_mode[4] = '{0, 0, 72, 20};
    logic [CFG_COLS_W-1:0] phase_cols[N_PHASES] = '{4'd8, 4'd15, 4'd1, 4'd4, 4'd0,
                                                    4'd9, 4'd6, 4'd2, 4'd8};
    int n_items;
    in_bus.valid     <= 1'b0;
    in_bus.row_sense <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_n   <= 1'b0;
    for (int c = 0; c < 8; c++) held_rows[c] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty scan, every key down, narrow settings, count lowered mid-scan
    write_columns(4'd8);
    repeat (8) send_row(6'h00);
    repeat (8) send_row(6'h3F);
    write_columns(4'd1);
    send_row(6'h2A);
    write_columns(4'd0);
    send_row(6'h00);
    write_columns(4'd8);
    send_row(6'h15);
    send_row(6'h3F);
    send_row(6'h01);
    send_row(6'h20);
    send_row(6'h2A);
    write_columns(4'd2);
    send_row(6'h3F);

    for (int p = 0; p < N_PHASES; p++) begin
      send_idle_pct  = idle_mode[p % 4];
      recv_stall_pct = stall_mode[p % 4];
      write_columns(phase_cols[p]);
      n_items = $urandom_range(36, 44);
      for (int i = 0; i < n_items; i++) send_row(next_row());
    end

    // back-pressure: sink held off while the source keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_columns(4'd8);
    hold_go = 1'b1;
    for (int i = 0; i < 40; i++) send_row(next_row());

    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("tb: %0d row-sense transactions over %0d column settings, %0d records checked",
             items_sent, settings_count, records_checked);
    $display("tb: covered idle and stall mixes and a %0d-cycle sink hold-off", HOLD_CYCLES);
    if (fail_count == 0 && open_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
